@@ sv/ffpa_pkg.sv @@
// Shared types, codes and defaults for the first-fit page allocator.
// Used by every module of the block but ffpa_ram; depends on nothing.
`timescale 1ns / 1ps

package ffpa_pkg;

   localparam int NUM_PAGES_DEF  = 2048;
   localparam int PAGE_SHIFT_DEF = 10;
   localparam logic [31:0] RAM_BASE = 32'h8000_0000;
   localparam logic [11:0] RESERVED_RESET = 12'd64;

   localparam logic [1:0] ACT_SETUP  = 2'd0;
   localparam logic [1:0] ACT_ALLOC  = 2'd1;
   localparam logic [1:0] ACT_FREE   = 2'd2;
   localparam logic [1:0] ACT_RESIZE = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_BADPTR = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [21:0] size_bytes;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [31:0] result_address;
      logic [1:0]  status;
      logic [11:0] granted_pages;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_SETUP, S_CHK_RD, S_CHK_EV,
      S_SRCH_RD, S_SRCH_EV, S_MARK, S_REL_SET, S_REL, S_DONE
   } state_type;

   typedef enum logic [2:0] {CUR_HOLD, CUR_ZERO, CUR_INC, CUR_START, CUR_REL} cur_op_type;
   typedef enum logic [2:0] {BW_NONE, BW_CLEAR, BW_SETUP, BW_MARK, BW_REL} busy_wr_type;
   typedef enum logic [2:0] {LW_NONE, LW_CLEAR, LW_SETUP, LW_GRANT, LW_FINAL} len_wr_type;
   typedef enum logic [2:0] {
      RES_HOLD, RES_ZERO, RES_NOFIT, RES_BADPTR, RES_ADDR_N, RES_ADDR_LEN, RES_GRANT
   } res_sel_type;

   typedef struct packed {
      logic        load_req;
      cur_op_type  cur_op;
      logic        rd_cur;
      logic        cnt_clr;
      logic        cnt_upd;
      logic        found_load;
      logic        len_load;
      logic        rel_load;
      logic        rel_trim;
      busy_wr_type busy_wr;
      len_wr_type  len_wr;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       addr_null;
      logic       n_zero;
      logic       n_too;
      logic       ptr_addr_ok;
      logic       ptr_ok;
      logic       n_lt_len;
      logic       n_eq_len;
      logic       found;
      logic       cur_last;
      logic       mark_last;
      logic       rel_done;
   } stat_type;

endpackage

@@ sv/ffpa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module ffpa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/ffpa_datapath.sv @@
// Datapath of the page allocator: request and result registers, cursor,
// run counter, the busy-bit and run-length RAMs. Depends on ffpa_pkg, ffpa_ram.
`timescale 1ns / 1ps

module ffpa_datapath #(
   parameter int NUM_PAGES  = ffpa_pkg::NUM_PAGES_DEF,
   parameter int PAGE_SHIFT = ffpa_pkg::PAGE_SHIFT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ffpa_pkg::req_type req_word,
   input  logic              csr_valid,
   input  logic [11:0]       csr_data,
   input  ffpa_pkg::cmd_type cmd,
   output ffpa_pkg::stat_type stat,
   output ffpa_pkg::rsp_type rsp_word
);

   localparam int PW = $clog2(NUM_PAGES);
   localparam int CW = $clog2(NUM_PAGES + 1);
   localparam int SW = CW + 1;
   localparam int AW = 32 - PAGE_SHIFT;

   ffpa_pkg::req_type req_ff, req_in;
   ffpa_pkg::rsp_type rsp_ff, rsp_in;
   logic [11:0]   reserved_ff, reserved_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] end_ff, end_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] endx_ff, endx_in;
   logic [CW-1:0] newlen_ff, newlen_in;

   logic [31:0]   off;
   logic [AW-1:0] pg_w;
   logic [PW-1:0] pg;
   logic [22:0]   n_w;
   logic [CW-1:0] n_val;
   logic          rd_busy;
   logic [CW-1:0] rd_len;
   logic [PW-1:0] raddr;
   logic [CW-1:0] cnt_next;
   logic [PW-1:0] start_calc;
   logic [31:0]   grant_addr;
   logic [31:0]   r_sat;
   logic          setup_bit;
   logic [SW-1:0] rel_cur_sum, rel_end_sum;
   logic [CW-1:0] rel_first;
   logic          bw_en, bw_data;
   logic          lw_en;
   logic [PW-1:0] lw_addr;
   logic [CW-1:0] lw_data;

   assign off   = req_ff.address - ffpa_pkg::RAM_BASE;
   assign pg_w  = off[31:PAGE_SHIFT];
   assign pg    = pg_w[PW-1:0];
   assign n_w   = ({1'b0, req_ff.size_bytes} + 23'((1 << PAGE_SHIFT) - 1)) >> PAGE_SHIFT;
   assign n_val = n_w[CW-1:0];
   assign raddr = cmd.rd_cur ? cur_ff[PW-1:0] : pg;

   assign cnt_next   = rd_busy ? '0 : cnt_ff + CW'(1);
   assign start_calc = PW'(cur_ff + CW'(1) - n_val);
   assign grant_addr = ffpa_pkg::RAM_BASE + (32'(start_calc) << PAGE_SHIFT);
   assign r_sat      = (32'(reserved_ff) > 32'(NUM_PAGES)) ? 32'(NUM_PAGES)
                                                            : 32'(reserved_ff);
   assign setup_bit  = 32'(cur_ff) < r_sat;

   assign rel_first   = cmd.rel_trim ? n_val : '0;
   assign rel_cur_sum = SW'(pg) + SW'(rel_first);
   assign rel_end_sum = SW'(pg) + SW'(len_ff);

   always_comb begin
      stat.action      = req_ff.action;
      stat.addr_null   = req_ff.address == '0;
      stat.n_zero      = n_w == '0;
      stat.n_too       = n_w > 23'(NUM_PAGES);
      stat.ptr_addr_ok = (off[PAGE_SHIFT-1:0] == '0) &&
                         ({{PAGE_SHIFT{1'b0}}, pg_w} < 32'(NUM_PAGES));
      stat.ptr_ok      = rd_busy && (rd_len != '0);
      stat.n_lt_len    = !stat.n_too && (n_val < rd_len);
      stat.n_eq_len    = !stat.n_too && (n_val == rd_len);
      stat.found       = cnt_next == n_val;
      stat.cur_last    = cur_ff == CW'(NUM_PAGES - 1);
      stat.mark_last   = cur_ff[PW-1:0] == end_ff;
      stat.rel_done    = cur_ff >= endx_ff;
   end

   always_comb begin
      req_in      = cmd.load_req ? req_word : req_ff;
      reserved_in = csr_valid ? csr_data : reserved_ff;
      cnt_in      = cnt_ff;
      end_in      = end_ff;
      len_in      = cmd.len_load ? rd_len : len_ff;
      endx_in     = endx_ff;
      newlen_in   = newlen_ff;
      cur_in      = cur_ff;
      rsp_in      = rsp_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_upd) begin
         cnt_in = cnt_next;
      end
      if (cmd.found_load) begin
         end_in = cur_ff[PW-1:0];
      end
      if (cmd.rel_load) begin
         endx_in   = (rel_end_sum > SW'(NUM_PAGES)) ? CW'(NUM_PAGES) : rel_end_sum[CW-1:0];
         newlen_in = rel_first;
      end
      case (cmd.cur_op)
         ffpa_pkg::CUR_ZERO:  cur_in = '0;
         ffpa_pkg::CUR_INC:   cur_in = cur_ff + CW'(1);
         ffpa_pkg::CUR_START: cur_in = CW'(start_calc);
         ffpa_pkg::CUR_REL: begin
            cur_in = (rel_cur_sum > SW'(NUM_PAGES)) ? CW'(NUM_PAGES) : rel_cur_sum[CW-1:0];
         end
         default:             cur_in = cur_ff;
      endcase
      case (cmd.res_sel)
         ffpa_pkg::RES_ZERO:     rsp_in = '{32'd0, ffpa_pkg::ST_OK, 12'd0};
         ffpa_pkg::RES_NOFIT:    rsp_in = '{32'd0, ffpa_pkg::ST_NOFIT, 12'd0};
         ffpa_pkg::RES_BADPTR:   rsp_in = '{32'd0, ffpa_pkg::ST_BADPTR, 12'd0};
         ffpa_pkg::RES_ADDR_N:   rsp_in = '{req_ff.address, ffpa_pkg::ST_OK, 12'(n_val)};
         ffpa_pkg::RES_ADDR_LEN: rsp_in = '{req_ff.address, ffpa_pkg::ST_OK, 12'(rd_len)};
         ffpa_pkg::RES_GRANT:    rsp_in = '{grant_addr, ffpa_pkg::ST_OK, 12'(n_val)};
         default:                rsp_in = rsp_ff;
      endcase
   end

   always_comb begin
      bw_en   = 1'b1;
      bw_data = 1'b0;
      case (cmd.busy_wr)
         ffpa_pkg::BW_CLEAR: bw_data = 1'b0;
         ffpa_pkg::BW_SETUP: bw_data = setup_bit;
         ffpa_pkg::BW_MARK:  bw_data = 1'b1;
         ffpa_pkg::BW_REL:   bw_data = 1'b0;
         default:            bw_en   = 1'b0;
      endcase
      lw_en   = 1'b1;
      lw_addr = cur_ff[PW-1:0];
      lw_data = '0;
      case (cmd.len_wr)
         ffpa_pkg::LW_CLEAR: lw_data = '0;
         ffpa_pkg::LW_SETUP: lw_data = CW'(setup_bit);
         ffpa_pkg::LW_GRANT: begin
            lw_addr = start_calc;
            lw_data = n_val;
         end
         ffpa_pkg::LW_FINAL: begin
            lw_addr = pg;
            lw_data = newlen_ff;
         end
         default:            lw_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= ffpa_pkg::RESERVED_RESET;
         cur_ff      <= '0;
      end else begin
         reserved_ff <= reserved_in;
         cur_ff      <= cur_in;
      end
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      cnt_ff    <= cnt_in;
      end_ff    <= end_in;
      len_ff    <= len_in;
      endx_ff   <= endx_in;
      newlen_ff <= newlen_in;
   end

   ffpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_busy_ram (
      .clock(clock),
      .we   (bw_en),
      .waddr(cur_ff[PW-1:0]),
      .wdata(bw_data),
      .raddr(raddr),
      .rdata(rd_busy)
   );

   ffpa_ram #(.WIDTH(CW), .DEPTH(NUM_PAGES)) u_len_ram (
      .clock(clock),
      .we   (lw_en),
      .waddr(lw_addr),
      .wdata(lw_data),
      .raddr(raddr),
      .rdata(rd_len)
   );

   assign rsp_word = rsp_ff;

endmodule

@@ sv/ffpa_ctrl.sv @@
// Controller of the page allocator: the sequencing state machine.
// Depends on ffpa_pkg; drives the datapath through cmd_type words.
`timescale 1ns / 1ps

module ffpa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ffpa_pkg::stat_type stat,
   output ffpa_pkg::cmd_type  cmd,
   output logic               busy,
   output logic               rsp_strobe
);

   ffpa_pkg::state_type state_ff, state_in;
   logic grow_ff, grow_in;
   logic trim_ff, trim_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffpa_pkg::S_CLEAR;
         grow_ff  <= 1'b0;
         trim_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         grow_ff  <= grow_in;
         trim_ff  <= trim_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      grow_in  = grow_ff;
      trim_in  = trim_ff;
      cmd      = '{load_req: 1'b0, cur_op: ffpa_pkg::CUR_HOLD, rd_cur: 1'b0,
                   cnt_clr: 1'b0, cnt_upd: 1'b0, found_load: 1'b0, len_load: 1'b0,
                   rel_load: 1'b0, rel_trim: 1'b0, busy_wr: ffpa_pkg::BW_NONE,
                   len_wr: ffpa_pkg::LW_NONE, res_sel: ffpa_pkg::RES_HOLD};
      case (state_ff)
         ffpa_pkg::S_CLEAR: begin
            cmd.busy_wr = ffpa_pkg::BW_CLEAR;
            cmd.len_wr  = ffpa_pkg::LW_CLEAR;
            if (stat.cur_last) begin
               cmd.cur_op = ffpa_pkg::CUR_ZERO;
               state_in   = ffpa_pkg::S_IDLE;
            end else begin
               cmd.cur_op = ffpa_pkg::CUR_INC;
            end
         end
         ffpa_pkg::S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               grow_in      = 1'b0;
               trim_in      = 1'b0;
               state_in     = ffpa_pkg::S_DECODE;
            end
         end
         ffpa_pkg::S_DECODE: begin
            cmd.cur_op  = ffpa_pkg::CUR_ZERO;
            cmd.cnt_clr = 1'b1;
            if (stat.action == ffpa_pkg::ACT_SETUP) begin
               cmd.res_sel = ffpa_pkg::RES_ZERO;
               state_in    = ffpa_pkg::S_SETUP;
            end else if (stat.action == ffpa_pkg::ACT_ALLOC ||
                         (stat.action == ffpa_pkg::ACT_RESIZE && stat.addr_null)) begin
               if (stat.n_zero || stat.n_too) begin
                  cmd.res_sel = ffpa_pkg::RES_NOFIT;
                  state_in    = ffpa_pkg::S_DONE;
               end else begin
                  state_in = ffpa_pkg::S_SRCH_RD;
               end
            end else if (stat.addr_null) begin
               cmd.res_sel = ffpa_pkg::RES_ZERO;
               state_in    = ffpa_pkg::S_DONE;
            end else if (!stat.ptr_addr_ok) begin
               cmd.res_sel = ffpa_pkg::RES_BADPTR;
               state_in    = ffpa_pkg::S_DONE;
            end else begin
               state_in = ffpa_pkg::S_CHK_RD;
            end
         end
         ffpa_pkg::S_SETUP: begin
            cmd.busy_wr = ffpa_pkg::BW_SETUP;
            cmd.len_wr  = ffpa_pkg::LW_SETUP;
            cmd.cur_op  = ffpa_pkg::CUR_INC;
            if (stat.cur_last) begin
               state_in = ffpa_pkg::S_DONE;
            end
         end
         ffpa_pkg::S_CHK_RD: begin
            state_in = ffpa_pkg::S_CHK_EV;
         end
         ffpa_pkg::S_CHK_EV: begin
            cmd.len_load = 1'b1;
            if (!stat.ptr_ok) begin
               cmd.res_sel = ffpa_pkg::RES_BADPTR;
               state_in    = ffpa_pkg::S_DONE;
            end else if (stat.action == ffpa_pkg::ACT_FREE || stat.n_zero) begin
               cmd.res_sel = ffpa_pkg::RES_ZERO;
               state_in    = ffpa_pkg::S_REL_SET;
            end else if (stat.n_lt_len) begin
               cmd.res_sel = ffpa_pkg::RES_ADDR_N;
               trim_in     = 1'b1;
               state_in    = ffpa_pkg::S_REL_SET;
            end else if (stat.n_eq_len) begin
               cmd.res_sel = ffpa_pkg::RES_ADDR_LEN;
               state_in    = ffpa_pkg::S_DONE;
            end else if (stat.n_too) begin
               cmd.res_sel = ffpa_pkg::RES_NOFIT;
               state_in    = ffpa_pkg::S_DONE;
            end else begin
               grow_in     = 1'b1;
               cmd.cur_op  = ffpa_pkg::CUR_ZERO;
               cmd.cnt_clr = 1'b1;
               state_in    = ffpa_pkg::S_SRCH_RD;
            end
         end
         ffpa_pkg::S_SRCH_RD: begin
            cmd.rd_cur = 1'b1;
            state_in   = ffpa_pkg::S_SRCH_EV;
         end
         ffpa_pkg::S_SRCH_EV: begin
            cmd.cnt_upd = 1'b1;
            if (stat.found) begin
               cmd.found_load = 1'b1;
               cmd.len_wr     = ffpa_pkg::LW_GRANT;
               cmd.res_sel    = ffpa_pkg::RES_GRANT;
               cmd.cur_op     = ffpa_pkg::CUR_START;
               state_in       = ffpa_pkg::S_MARK;
            end else if (stat.cur_last) begin
               cmd.res_sel = ffpa_pkg::RES_NOFIT;
               state_in    = ffpa_pkg::S_DONE;
            end else begin
               cmd.cur_op = ffpa_pkg::CUR_INC;
               state_in   = ffpa_pkg::S_SRCH_RD;
            end
         end
         ffpa_pkg::S_MARK: begin
            cmd.busy_wr = ffpa_pkg::BW_MARK;
            cmd.cur_op  = ffpa_pkg::CUR_INC;
            if (stat.mark_last) begin
               state_in = grow_ff ? ffpa_pkg::S_REL_SET : ffpa_pkg::S_DONE;
            end
         end
         ffpa_pkg::S_REL_SET: begin
            cmd.rel_load = 1'b1;
            cmd.rel_trim = trim_ff;
            cmd.cur_op   = ffpa_pkg::CUR_REL;
            state_in     = ffpa_pkg::S_REL;
         end
         ffpa_pkg::S_REL: begin
            if (stat.rel_done) begin
               cmd.len_wr = ffpa_pkg::LW_FINAL;
               state_in   = ffpa_pkg::S_DONE;
            end else begin
               cmd.busy_wr = ffpa_pkg::BW_REL;
               cmd.cur_op  = ffpa_pkg::CUR_INC;
            end
         end
         ffpa_pkg::S_DONE: begin
            state_in = ffpa_pkg::S_IDLE;
         end
         default: begin
            state_in = ffpa_pkg::S_IDLE;
         end
      endcase
   end

   assign busy       = state_ff != ffpa_pkg::S_IDLE;
   assign rsp_strobe = state_ff == ffpa_pkg::S_DONE;

endmodule

@@ sv/first_fit_page_allocator.sv @@
// Top level of the first-fit page allocator: controller plus datapath.
// Depends on ffpa_pkg, ffpa_ctrl, ffpa_datapath.
//
// A request word (action, size_bytes, address) is taken at a rising edge
// with start high and busy low. The result word appears on rsp_word,
// marked by rsp_strobe for exactly one cycle; the receiver cannot stall it.
// busy stays high from acceptance until the cycle after the strobe.
// Setup writes every page. An alloc scans the busy RAM page by page up
// to the end of the first fitting run, then marks each granted page.
// Free and trim clear each released page after a check of the pointer.
// A growing resize adds a search, a mark and a release of the old run.
// Each page of the scan is a read state then a test state on the busy
// RAM port. Reset runs a clearing pass over all NUM_PAGES pages with busy
// high; it does not run setup. reserved_pages returns to 64. The csr
// channel is always ready; the user must write it only while idle, and
// the block itself does not enforce this.
`timescale 1ns / 1ps

module first_fit_page_allocator #(
   parameter int NUM_PAGES  = ffpa_pkg::NUM_PAGES_DEF,
   parameter int PAGE_SHIFT = ffpa_pkg::PAGE_SHIFT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffpa_pkg::req_type req_word,
   output logic              rsp_strobe,
   output ffpa_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [11:0]       csr_data
);

   ffpa_pkg::cmd_type  cmd;
   ffpa_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   ffpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_strobe(rsp_strobe)
   );

   ffpa_datapath #(.NUM_PAGES(NUM_PAGES), .PAGE_SHIFT(PAGE_SHIFT)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .csr_valid(csr_valid),
      .csr_data (csr_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_word (rsp_word)
   );

endmodule

@@ sv/ffpa_checker.sv @@
// Port-level checker for the page allocator, bound to the top level.
// Depends on ffpa_pkg and first_fit_page_allocator.
`timescale 1ns / 1ps

module ffpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input ffpa_pkg::rsp_type rsp_word
);

   a_reset_clears: assert property (@(posedge clock) reset |=> busy)
      else $error("busy not raised for the clearing pass after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe lasted more than one cycle");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status != ffpa_pkg::ST_OK) |->
      (rsp_word.result_address == '0 && rsp_word.granted_pages == '0))
      else $error("failed result carries an address or length");

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_strobe(rsp_strobe),
   .rsp_word  (rsp_word)
);

@@ tb/sv/tb_first_fit_page_allocator.sv @@
// Self-checking testbench for first_fit_page_allocator: a directed table, then random
// request words, checked against fixed replies or an in-bench allocator predictor.
// Depends on ffpa_pkg and first_fit_page_allocator.
`timescale 1ns / 1ps

module tb_first_fit_page_allocator;
   import ffpa_pkg::*;

   localparam int NPG = NUM_PAGES_DEF;
   localparam int PSH = PAGE_SHIFT_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_word = '0;
   logic rsp_strobe;
   rsp_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [11:0] csr_data = '0;

   first_fit_page_allocator uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic        page_used [NPG];
   logic [11:0] run_len [NPG];
   logic [11:0] reserved_shadow;
   rsp_type     pending_replies [$];
   int          errors = 0;
   int          words_sent = 0;
   int          replies_seen = 0;
   bit          no_idle = 1'b0;

   typedef struct {
      req_type word;
      bit      fixed;
      rsp_type reply;
   } row_type;

   function automatic logic [31:0] page_address(int pg);
      return RAM_BASE + (32'(pg) << PSH);
   endfunction

   function automatic rsp_type claim_run(int n);
      rsp_type r;
      int count;
      int s;
      r = '{32'd0, ST_NOFIT, 12'd0};
      if (n == 0 || n > NPG) return r;
      count = 0;
      for (int x = 0; x < NPG; x++) begin
         count = page_used[x] ? 0 : count + 1;
         if (count == n) begin
            s = x + 1 - n;
            for (int y = 0; y < n; y++) page_used[s + y] = 1'b1;
            run_len[s] = 12'(n);
            r = '{page_address(s), ST_OK, 12'(n)};
            return r;
         end
      end
      return r;
   endfunction

   function automatic void release_pages(int pg, int first, int len);
      for (int y = first; y < len && pg + y < NPG; y++) page_used[pg + y] = 1'b0;
   endfunction

   function automatic rsp_type predict_reply(req_type w);
      rsp_type r;
      int n;
      int lim;
      int pg;
      int len;
      logic [31:0] off;
      r = '{32'd0, ST_OK, 12'd0};
      n = (int'(w.size_bytes) + (1 << PSH) - 1) >> PSH;
      if (w.action == ACT_SETUP) begin
         lim = reserved_shadow > NPG ? NPG : int'(reserved_shadow);
         for (int x = 0; x < NPG; x++) begin
            page_used[x] = x < lim;
            run_len[x] = x < lim ? 12'd1 : 12'd0;
         end
         return r;
      end
      if (w.action == ACT_ALLOC || (w.action == ACT_RESIZE && w.address == 0))
         return claim_run(n);
      if (w.action == ACT_FREE && w.address == 0) return r;
      off = w.address - RAM_BASE;
      pg = int'(off >> PSH);
      if ((off & ((32'd1 << PSH) - 1)) != 0 || off >= (32'(NPG) << PSH) || !page_used[pg]
          || run_len[pg] == 0) begin
         r.status = ST_BADPTR;
         return r;
      end
      len = int'(run_len[pg]);
      if (w.action == ACT_FREE || n == 0) begin
         release_pages(pg, 0, len);
         run_len[pg] = 12'd0;
      end else if (n < len) begin
         release_pages(pg, n, len);
         run_len[pg] = 12'(n);
         r = '{w.address, ST_OK, 12'(n)};
      end else if (n == len) begin
         r = '{w.address, ST_OK, 12'(len)};
      end else begin
         r = claim_run(n);
         if (r.status == ST_OK) begin
            release_pages(pg, 0, len);
            run_len[pg] = 12'd0;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         replies_seen++;
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, rsp_word);
            errors++;
         end else begin
            rsp_type e;
            e = pending_replies.pop_front();
            if (e.result_address !== rsp_word.result_address) begin
               $display("%0t: result_address expected %h actual %h", $time,
                        e.result_address, rsp_word.result_address);
               errors++;
            end
            if (e.status !== rsp_word.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status,
                        rsp_word.status);
               errors++;
            end
            if (e.granted_pages !== rsp_word.granted_pages) begin
               $display("%0t: granted_pages expected %0d actual %0d", $time,
                        e.granted_pages, rsp_word.granted_pages);
               errors++;
            end
         end
      end
   end

   task automatic send_word(req_type w, bit fixed, rsp_type typed);
      rsp_type p;
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      p = predict_reply(w);
      pending_replies.push_back(fixed ? typed : p);
      words_sent++;
      if (!no_idle && $urandom_range(0, 99) < 22) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_replies.size() != 0 || busy) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reserved(logic [11:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      reserved_shadow = v;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_run();
      int starts [$];
      for (int x = 0; x < NPG; x++)
         if (page_used[x] && run_len[x] != 0) starts.push_back(x);
      if (starts.size() == 0) return 32'd0;
      return page_address(starts[$urandom_range(0, starts.size() - 1)]);
   endfunction

   function automatic logic [21:0] pick_size();
      int k;
      k = $urandom_range(0, 9);
      if (k < 8) return 22'($urandom_range(0, 8192));
      if (k < 9) return 22'($urandom_range(0, 65536));
      return 22'($urandom);
   endfunction

   function automatic req_type random_word();
      req_type w;
      int k;
      k = $urandom_range(0, 99);
      w.size_bytes = pick_size();
      w.address = 32'd0;
      if (k < 40) w.action = ACT_ALLOC;
      else if (k < 65) begin
         w.action = ACT_FREE;
         w.address = pick_run();
      end else if (k < 85) begin
         w.action = ACT_RESIZE;
         w.address = pick_run();
      end else if (k < 96) begin
         w.action = $urandom_range(0, 1) ? ACT_FREE : ACT_RESIZE;
         w.address = $urandom;
         w.size_bytes = 22'($urandom);
      end else w.action = ACT_SETUP;
      return w;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) send_word(random_word(), 1'b0, '0);
   endtask

   row_type rows [$];

   initial begin
      reserved_shadow = RESERVED_RESET;
      for (int x = 0; x < NPG; x++) begin
         page_used[x] = 1'b0;
         run_len[x] = 12'd0;
      end
      rows = '{
         '{'{ACT_ALLOC, 22'd2097152, 32'd0}, 1, '{RAM_BASE, ST_OK, 12'd2048}},
         '{'{ACT_SETUP, 22'h3FFFFF, 32'hFFFFFFFF}, 1, '{32'd0, ST_OK, 12'd0}},
         '{'{ACT_ALLOC, 22'd0, 32'd0}, 1, '{32'd0, ST_NOFIT, 12'd0}},
         '{'{ACT_ALLOC, 22'd1, 32'd0}, 0, '0},
         '{'{ACT_ALLOC, 22'd1024, 32'd0}, 0, '0},
         '{'{ACT_ALLOC, 22'd1025, 32'd0}, 0, '0},
         '{'{ACT_RESIZE, 22'd3000, 32'd0}, 0, '0},
         '{'{ACT_ALLOC, 22'h3FFFFF, 32'd0}, 1, '{32'd0, ST_NOFIT, 12'd0}},
         '{'{ACT_ALLOC, 22'd2097152, 32'd0}, 1, '{32'd0, ST_NOFIT, 12'd0}},
         '{'{ACT_FREE, 22'd0, 32'd0}, 1, '{32'd0, ST_OK, 12'd0}},
         '{'{ACT_FREE, 22'd0, 32'h80000001}, 1, '{32'd0, ST_BADPTR, 12'd0}},
         '{'{ACT_FREE, 22'd0, 32'h7FFFFC00}, 1, '{32'd0, ST_BADPTR, 12'd0}},
         '{'{ACT_FREE, 22'd0, 32'h80200000}, 1, '{32'd0, ST_BADPTR, 12'd0}},
         '{'{ACT_FREE, 22'd0, 32'hFFFFFFFF}, 1, '{32'd0, ST_BADPTR, 12'd0}},
         '{'{ACT_FREE, 22'd0, 32'h80019000}, 1, '{32'd0, ST_BADPTR, 12'd0}},
         '{'{ACT_FREE, 22'd0, 32'h80000000}, 1, '{32'd0, ST_OK, 12'd0}},
         '{'{ACT_RESIZE, 22'd1, 32'h80010800}, 0, '0},
         '{'{ACT_RESIZE, 22'd3072, 32'h80011000}, 0, '0},
         '{'{ACT_RESIZE, 22'd5000, 32'h80010000}, 0, '0},
         '{'{ACT_RESIZE, 22'd0, 32'h80010400}, 1, '{32'd0, ST_OK, 12'd0}},
         '{'{ACT_FREE, 22'd0, 32'h80010800}, 0, '0},
         '{'{ACT_FREE, 22'd0, 32'h80010800}, 1, '{32'd0, ST_BADPTR, 12'd0}},
         '{'{ACT_RESIZE, 22'd8, 32'h80000004}, 1, '{32'd0, ST_BADPTR, 12'd0}},
         '{'{ACT_RESIZE, 22'd2097152, 32'h80011000}, 1, '{32'd0, ST_NOFIT, 12'd0}}
      };
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) send_word(rows[i].word, rows[i].fixed, rows[i].reply);
      write_reserved(12'd0);
      send_word('{ACT_SETUP, 22'd0, 32'd0}, 1'b0, '0);
      random_phase(20);
      no_idle = 1'b1;
      random_phase(25);
      no_idle = 1'b0;
      drain();
      random_phase(15);
      write_reserved(12'd2048);
      send_word('{ACT_SETUP, 22'd0, 32'd0}, 1'b0, '0);
      random_phase(10);
      write_reserved(12'd4095);
      send_word('{ACT_SETUP, 22'd0, 32'd0}, 1'b0, '0);
      random_phase(10);
      write_reserved(12'($urandom_range(0, 1500)));
      send_word('{ACT_SETUP, 22'd0, 32'd0}, 1'b0, '0);
      random_phase(20);
      write_reserved(RESERVED_RESET);
      send_word('{ACT_SETUP, 22'd0, 32'd0}, 1'b0, '0);
      random_phase(15);
      drain();
      repeat (50) @(posedge clock);
      $display("Sent %0d request words and checked %0d result words across six", words_sent,
               replies_seen);
      $display("reserved-page settings, including none, all and saturated.");
      if (errors == 0 && pending_replies.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ first_fit_page_allocator.f @@
sv/ffpa_pkg.sv
sv/ffpa_ram.sv
sv/ffpa_datapath.sv
sv/ffpa_ctrl.sv
sv/first_fit_page_allocator.sv
sv/ffpa_checker.sv
tb/sv/tb_first_fit_page_allocator.sv
